@@ rtl/voxel_grid_overlap_counter_assert.svh @@
// ----------------------------------------------------------------------------
// voxel_grid_overlap_counter_assert
// Assertion macros shared by the voxel grid overlap counter modules.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_OVERLAP_COUNTER_ASSERT_SVH
`define VOXEL_GRID_OVERLAP_COUNTER_ASSERT_SVH

// same-cycle implication
`define VGOC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgoc assertion failed (same cycle)");

// next-cycle implication
`define VGOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgoc assertion failed (next cycle)");

`endif

@@ rtl/vgoc_pkg.sv @@
// ----------------------------------------------------------------------------
// vgoc_pkg
// Types and constants of the voxel grid overlap counter.
// ----------------------------------------------------------------------------
package vgoc_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 18;
    localparam int SHIFT_W   = 16;
    localparam int BINS_W    = 7;
    localparam int INV_RES_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int CNT_OUT_W = 19;
    localparam int RATIO_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int OFS_W     = 9;
    localparam int PROD_W    = 34;

    localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BINS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RES = 1'b1;

    localparam logic [BINS_W-1:0]    BINS_RESET    = 7'd64;
    localparam logic [INV_RES_W-1:0] INV_RES_RESET = 16'd1280;
    localparam logic [7:0]           OFS_LIMIT     = 8'd255;
    localparam logic [RATIO_W-1:0]   RATIO_MAX     = 17'd65536;

    typedef struct packed {
        logic latch;
        logic clr_init;
        logic clr_step;
        logic wr_a;
        logic wr_b;
        logic scan_init;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic res_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic n_zero;
        logic clr_last;
        logic scan_last;
        logic div_last;
    } t_dp_stat;

endpackage

@@ rtl/voxel_grid_overlap_counter.sv @@
// ----------------------------------------------------------------------------
// voxel_grid_overlap_counter
// Compute: scans n^3 cells, n = clamped bins, with one bitmap read pair per
//   scanned cell, then runs a bit-serial divider; busy stays high until the
//   o_valid strobe, so a new compute waits for the last one. Writes: A, and B with a read first.
// Clear: a sweep of all MAX_BINS^3 cells, busy high; after reset the same sweep runs.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module voxel_grid_overlap_counter import vgoc_pkg::*; #(
    parameter int MAX_BINS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [IDX_W-1:0]     i_cell_index,
    input  logic                 i_occupied,
    input  logic [SHIFT_W-1:0]   i_shift_x,
    input  logic [SHIFT_W-1:0]   i_shift_y,
    input  logic [SHIFT_W-1:0]   i_shift_z,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_valid,
    output logic [CNT_OUT_W-1:0] o_overlap_cells,
    output logic [CNT_OUT_W-1:0] o_b_cells,
    output logic [RATIO_W-1:0]   o_overlap_ratio,
    output logic                 o_ratio_valid
);

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    assign o_cfg_ready = 1'b1;

    vgoc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (busy)
    );

    vgoc_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cell_index    (i_cell_index),
        .i_occupied      (i_occupied),
        .i_shift_x       (i_shift_x),
        .i_shift_y       (i_shift_y),
        .i_shift_z       (i_shift_z),
        .i_cfg_wr        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_overlap_cells (o_overlap_cells),
        .o_b_cells       (o_b_cells),
        .o_overlap_ratio (o_overlap_ratio),
        .o_ratio_valid   (o_ratio_valid)
    );

endmodule

@@ rtl/vgoc_ctrl.sv @@
// ----------------------------------------------------------------------------
// vgoc_ctrl
// Command sequencer: clear sweep, setup wait, cell writes, scan and divide.
// ----------------------------------------------------------------------------
`include "voxel_grid_overlap_counter_assert.svh"

module vgoc_ctrl import vgoc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CMD_W-1:0] i_command,
    input  t_dp_stat         i_stat,
    output t_ctrl_cmd        o_cmd,
    output logic             o_busy
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_SETUP   = 4'd2;
    localparam logic [3:0] S_WR_A    = 4'd3;
    localparam logic [3:0] S_WRB_RD  = 4'd4;
    localparam logic [3:0] S_WRB_UPD = 4'd5;
    localparam logic [3:0] S_SCAN    = 4'd6;
    localparam logic [3:0] S_DRAIN   = 4'd7;
    localparam logic [3:0] S_DIV_LD  = 4'd8;
    localparam logic [3:0] S_DIV     = 4'd9;
    localparam logic [3:0] S_RES     = 4'd10;

    // datapath setup pipeline depth minus one
    localparam logic [2:0] SETUP_LAST = 3'd4;

    logic [3:0]       r_state, n_state;
    logic [2:0]       r_cnt, n_cnt;
    logic [CMD_W-1:0] r_cmd, n_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_cmd       = i_command;
                    n_cnt       = '0;
                    n_state     = S_SETUP;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SETUP: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == SETUP_LAST) begin
                    unique case (r_cmd)
                        CMD_WR_A: begin
                            n_state = S_WR_A;
                        end
                        CMD_WR_B: begin
                            n_state = S_WRB_RD;
                        end
                        CMD_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_state        = S_CLR;
                        end
                        CMD_COMPUTE: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = i_stat.n_zero ? S_DRAIN : S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WR_A: begin
                o_cmd.wr_a = 1'b1;
                n_state    = S_IDLE;
            end
            S_WRB_RD: begin
                n_state = S_WRB_UPD;
            end
            S_WRB_UPD: begin
                o_cmd.wr_b = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DIV_LD;
            end
            S_DIV_LD: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                o_cmd.res_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_cmd   <= CMD_WR_A;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cmd   <= n_cmd;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `VGOC_ASSERT_NEXT(a_accept_setup, i_clk, i_rst_n, i_start && r_state == S_IDLE, r_state == S_SETUP)
    `VGOC_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, o_cmd.res_load, r_state == S_IDLE)
    `VGOC_ASSERT_IMPL(a_drain_entry, i_clk, i_rst_n, r_state == S_DRAIN, $past(r_state) == S_SCAN || $past(r_state) == S_SETUP)

endmodule

@@ rtl/vgoc_dp.sv @@
// ----------------------------------------------------------------------------
// vgoc_dp
// Datapath: grid bitmaps, config registers, offset setup, scan counters,
// overlap count and restoring divider for the ratio.
// ----------------------------------------------------------------------------
`include "voxel_grid_overlap_counter_assert.svh"

module vgoc_dp import vgoc_pkg::*; #(
    parameter int MAX_BINS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_stat             o_stat,
    input  logic [IDX_W-1:0]     i_cell_index,
    input  logic                 i_occupied,
    input  logic [SHIFT_W-1:0]   i_shift_x,
    input  logic [SHIFT_W-1:0]   i_shift_y,
    input  logic [SHIFT_W-1:0]   i_shift_z,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_valid,
    output logic [CNT_OUT_W-1:0] o_overlap_cells,
    output logic [CNT_OUT_W-1:0] o_b_cells,
    output logic [RATIO_W-1:0]   o_overlap_ratio,
    output logic                 o_ratio_valid
);

    localparam int DEPTH = MAX_BINS * MAX_BINS * MAX_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(MAX_BINS + 1);
    localparam int NNW   = 2 * NW;
    localparam int BW    = $clog2(MAX_BINS);
    localparam int SW    = ((BW + 1 > OFS_W) ? BW + 1 : OFS_W) + 1;
    localparam int XW    = (CW > IDX_W) ? CW : IDX_W;
    localparam int QW    = CW + FRAC_W;
    localparam int DCW   = $clog2(QW);

    // -t * inv_resolution, Q.16
    function automatic logic signed [PROD_W-1:0] ofs_prod(
        input logic signed [SHIFT_W-1:0] t,
        input logic [INV_RES_W-1:0]      inv
    );
        logic signed [SHIFT_W:0] nt;
        nt = -((SHIFT_W + 1)'(t));
        return nt * $signed({1'b0, inv});
    endfunction

    // drop fraction toward zero, saturate magnitude
    function automatic logic signed [OFS_W-1:0] ofs_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic [PROD_W-1:0] mag;
        logic [7:0]        m8;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        m8  = (mag[PROD_W-1:FRAC_W] > (PROD_W - FRAC_W)'(OFS_LIMIT)) ? OFS_LIMIT
                                                                    : mag[FRAC_W+7:FRAC_W];
        return p[PROD_W-1] ? -$signed({1'b0, m8}) : $signed({1'b0, m8});
    endfunction

    function automatic logic axis_ok(
        input logic [BW-1:0]           c,
        input logic signed [OFS_W-1:0] o,
        input logic [NW-1:0]           n
    );
        logic signed [SW-1:0] s;
        s = $signed({{(SW-BW){1'b0}}, c}) + SW'(o);
        return !s[SW-1] && (s < $signed({{(SW-NW){1'b0}}, n}));
    endfunction

    // config
    logic [BINS_W-1:0]    r_bins;
    logic [INV_RES_W-1:0] r_inv;

    // latched item
    logic [IDX_W-1:0]   r_idx;
    logic               r_occ;
    logic [SHIFT_W-1:0] r_tx, r_ty, r_tz;

    // setup pipeline
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [OFS_W-1:0]  r_ox, r_oy, r_oz;
    logic [NW-1:0]            r_n;
    logic [NNW-1:0]           r_nn;
    logic [CW-1:0]            r_limit;
    logic [AW-1:0]            r_dx, r_dxy, r_dofs;

    // memories
    logic r_mem_a [DEPTH];
    logic r_mem_b [DEPTH];
    logic r_a_q, r_b_q;

    // scan / count
    logic [AW-1:0] r_addr;
    logic [BW-1:0] r_x, r_y, r_z;
    logic          r_chk;
    logic [CW-1:0] r_overlap;
    logic [CW-1:0] r_bcount;

    // divider
    logic [CW-1:0]  r_rem;
    logic [QW-1:0]  r_quo;
    logic [DCW-1:0] r_dcnt;

    // results
    logic                 r_strobe;
    logic [CNT_OUT_W-1:0] r_res_overlap, r_res_b;
    logic [RATIO_W-1:0]   r_res_ratio;
    logic                 r_res_valid;

    logic          idx_ok;
    logic [NW-1:0] n_m1;
    logic          x_last, y_last, z_last;
    logic          inr;
    logic [AW-1:0] rd_addr_b, wr_addr;
    logic          we_a, we_b, wd_a, wd_b;
    logic [CW:0]   rem_sh;
    logic [CW+1:0] diff;
    logic          ge;

    assign idx_ok = XW'(r_idx) < XW'(r_limit);
    assign n_m1   = r_n - NW'(1);
    assign x_last = NW'(r_x) == n_m1;
    assign y_last = NW'(r_y) == n_m1;
    assign z_last = NW'(r_z) == n_m1;
    assign inr    = axis_ok(r_x, r_ox, r_n) && axis_ok(r_y, r_oy, r_n)
                    && axis_ok(r_z, r_oz, r_n);

    assign rd_addr_b = i_cmd.scan_step ? r_addr + r_dofs : AW'(r_idx);
    assign wr_addr   = i_cmd.clr_step ? r_addr : AW'(r_idx);
    assign we_a      = i_cmd.clr_step || (i_cmd.wr_a && idx_ok);
    assign we_b      = i_cmd.clr_step || (i_cmd.wr_b && idx_ok);
    assign wd_a      = !i_cmd.clr_step && r_occ;
    assign wd_b      = !i_cmd.clr_step && r_occ;

    assign rem_sh = {r_rem, r_quo[QW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_bcount};
    assign ge     = !diff[CW+1];

    assign o_stat.n_zero    = (r_n == '0);
    assign o_stat.clr_last  = (r_addr == AW'(DEPTH - 1));
    assign o_stat.scan_last = x_last && y_last && z_last;
    assign o_stat.div_last  = (r_dcnt == DCW'(QW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins <= BINS_RESET;
            r_inv  <= INV_RES_RESET;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                REG_BINS:    r_bins <= i_cfg_data[BINS_W-1:0];
                REG_INV_RES: r_inv  <= i_cfg_data;
                default:     r_bins <= r_bins;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_idx <= i_cell_index;
            r_occ <= i_occupied;
            r_tx  <= i_shift_x;
            r_ty  <= i_shift_y;
            r_tz  <= i_shift_z;
        end
    end

    // free-running setup pipeline from the latched item
    always_ff @(posedge i_clk) begin
        r_px    <= ofs_prod(r_tx, r_inv);
        r_py    <= ofs_prod(r_ty, r_inv);
        r_pz    <= ofs_prod(r_tz, r_inv);
        r_n     <= ({1'b0, r_bins} > (BINS_W + 1)'(MAX_BINS)) ? NW'(MAX_BINS) : NW'(r_bins);
        r_ox    <= ofs_sat(r_px);
        r_oy    <= ofs_sat(r_py);
        r_oz    <= ofs_sat(r_pz);
        r_nn    <= NNW'(r_n) * NNW'(r_n);
        r_limit <= CW'(r_nn) * CW'(r_n);
        r_dx    <= AW'(r_ox) * AW'(r_n);
        r_dxy   <= (r_dx + AW'(r_oy)) * AW'(r_n);
        r_dofs  <= r_dxy + AW'(r_oz);
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[wr_addr] <= wd_a;
        end
        r_a_q <= r_mem_a[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[wr_addr] <= wd_b;
        end
        r_b_q <= r_mem_b[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_chk    <= 1'b0;
            r_bcount <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_chk    <= i_cmd.scan_step && inr;
            r_strobe <= i_cmd.res_load;
            if (i_cmd.clr_init || i_cmd.scan_init) begin
                r_addr <= '0;
            end else if (i_cmd.clr_step || i_cmd.scan_step) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.clr_init) begin
                r_bcount <= '0;
            end else if (i_cmd.wr_b && idx_ok) begin
                if (r_b_q && !r_occ) begin
                    r_bcount <= r_bcount - CW'(1);
                end else if (!r_b_q && r_occ) begin
                    r_bcount <= r_bcount + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else if (i_cmd.scan_step) begin
            if (z_last) begin
                r_z <= '0;
                if (y_last) begin
                    r_y <= '0;
                    r_x <= r_x + BW'(1);
                end else begin
                    r_y <= r_y + BW'(1);
                end
            end else begin
                r_z <= r_z + BW'(1);
            end
        end
        if (i_cmd.scan_init) begin
            r_overlap <= '0;
        end else if (r_chk && r_a_q && r_b_q) begin
            r_overlap <= r_overlap + CW'(1);
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= {r_overlap, {FRAC_W{1'b0}}};
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? diff[CW-1:0] : rem_sh[CW-1:0];
            r_quo  <= {r_quo[QW-2:0], ge};
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_overlap <= CNT_OUT_W'(r_overlap);
            r_res_b       <= CNT_OUT_W'(r_bcount);
            if (r_bcount == '0) begin
                r_res_ratio <= '0;
                r_res_valid <= 1'b0;
            end else begin
                r_res_ratio <= (r_quo > QW'(RATIO_MAX)) ? RATIO_MAX : r_quo[RATIO_W-1:0];
                r_res_valid <= 1'b1;
            end
        end
    end

    assign o_valid         = r_strobe;
    assign o_overlap_cells = r_res_overlap;
    assign o_b_cells       = r_res_b;
    assign o_overlap_ratio = r_res_ratio;
    assign o_ratio_valid   = r_res_valid;

    `VGOC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_strobe, !r_strobe)
    `VGOC_ASSERT_IMPL(a_chk_from_scan, i_clk, i_rst_n, r_chk, $past(i_cmd.scan_step))
    `VGOC_ASSERT_IMPL(a_empty_ratio, i_clk, i_rst_n, r_strobe && !r_res_valid, r_res_ratio == '0)

endmodule
